@@ rtl/amcs_pkg.sv @@
// Shared types, command codes and frame constants for the audio module command sequencer.
`timescale 1ns / 1ps
package amcs_pkg;

	typedef struct packed {
		logic [2:0]  mode;
		logic [15:0] track;
		logic [7:0]  volume_value;
	} cmd_item_t;

	typedef struct packed {
		logic [7:0]  frame_byte;
		logic        last;
		logic [15:0] current_track;
		logic [4:0]  current_volume;
	} frame_item_t;

	typedef struct packed {
		logic       load;
		logic       div_start;
		logic       apply;
		logic       emit;
		logic       last;
		logic [1:0] frame_sel;
		logic [3:0] byte_sel;
	} ctrl_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_done;
		logic has_out;
		logic need_init;
		logic out_free;
	} dp_status_t;

	localparam logic [2:0] MODE_TICK   = 3'd0;
	localparam logic [2:0] MODE_PLAY   = 3'd1;
	localparam logic [2:0] MODE_NEXT   = 3'd2;
	localparam logic [2:0] MODE_PREV   = 3'd3;
	localparam logic [2:0] MODE_REPLAY = 3'd4;
	localparam logic [2:0] MODE_STOP   = 3'd5;
	localparam logic [2:0] MODE_VOLUME = 3'd6;

	localparam logic [1:0] FRM_SELECT = 2'd0;
	localparam logic [1:0] FRM_VOLUME = 2'd1;
	localparam logic [1:0] FRM_MAIN   = 2'd2;

	localparam logic [3:0] BYTE_FIRST = 4'd0;
	localparam logic [3:0] BYTE_FINAL = 4'd9;

	localparam logic [7:0] FRAME_START   = 8'h7E;
	localparam logic [7:0] FRAME_VERSION = 8'hFF;
	localparam logic [7:0] FRAME_LENGTH  = 8'h06;
	localparam logic [7:0] FRAME_NOACK   = 8'h00;
	localparam logic [7:0] FRAME_END     = 8'hEF;

	localparam logic [7:0]  OP_SELECT_DEVICE = 8'h09;
	localparam logic [7:0]  OP_SET_VOLUME    = 8'h06;
	localparam logic [7:0]  OP_PLAY_TRACK    = 8'h12;
	localparam logic [7:0]  OP_STOP          = 8'h16;
	localparam logic [15:0] DEVICE_SD        = 16'h0002;

	localparam logic [4:0]  VOLUME_MAX         = 5'd30;
	localparam logic [4:0]  VOLUME_RESET       = 5'd20;
	localparam logic [15:0] TRACK_COUNT_RESET  = 16'd0;
	localparam logic [15:0] STARTUP_DELAY_RESET = 16'd1500;

	localparam logic REG_TRACK_COUNT   = 1'b0;
	localparam logic REG_STARTUP_DELAY = 1'b1;

endpackage

@@ rtl/amcs_div.sv @@
// Iterative 16-bit remainder unit, one restoring step per cycle.
`timescale 1ns / 1ps
module amcs_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] dividend,
	input  logic [15:0] divisor,
	output logic        done,
	output logic [15:0] remainder
);

	logic        busy_q;
	logic        done_q;
	logic [3:0]  cnt_q;
	logic [15:0] rem_q;
	logic [15:0] dvd_q;
	logic [15:0] dsr_q;
	logic [16:0] trial;
	logic [16:0] diff;
	logic        fits;

	assign trial = {rem_q, dvd_q[15]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 4'd1;
			if (cnt_q == 4'd15) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[15:0] : trial[15:0];
			dvd_q <= {dvd_q[14:0], 1'b0};
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && dsr_q != 16'd0) |-> rem_q < dsr_q)
		else $error("remainder not below divisor");

endmodule

@@ rtl/amcs_dp.sv @@
// Datapath: command latch, player state, remainder unit, frame byte builder and output register.
`timescale 1ns / 1ps
module amcs_dp
	import amcs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_item_t   command,
	input  logic [15:0] track_count,
	input  logic [15:0] startup_delay,
	input  ctrl_cmd_t   ctl,
	output dp_status_t  status,
	output logic        frame_valid,
	input  logic        frame_stall,
	output frame_item_t frame
);

	logic [2:0]  mode_q;
	logic [15:0] track_in_q;
	logic [7:0]  volume_in_q;
	logic        init_done_q;
	logic [15:0] elapsed_q;
	logic [15:0] track_now_q;
	logic [4:0]  volume_now_q;
	logic [7:0]  main_op_q;
	logic [15:0] main_param_q;
	logic        out_valid_q;
	frame_item_t out_q;

	logic        div_done;
	logic [15:0] rem;
	logic        count_nz;
	logic        ready;
	logic        plays;
	logic        need_init;
	logic        has_out;
	logic [15:0] new_track;
	logic [4:0]  vol_clamped;
	logic [7:0]  op;
	logic [15:0] param;
	logic [15:0] sum;
	logic [15:0] chk;
	logic [7:0]  byte_val;

	amcs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (ctl.div_start),
		.dividend  (track_now_q),
		.divisor   (track_count),
		.done      (div_done),
		.remainder (rem)
	);

	assign count_nz    = track_count != 16'd0;
	assign ready       = elapsed_q >= startup_delay;
	assign vol_clamped = (volume_in_q > {3'd0, VOLUME_MAX}) ? VOLUME_MAX : volume_in_q[4:0];

	always_comb begin
		plays     = 1'b0;
		new_track = track_now_q;
		case (mode_q)
			MODE_PLAY: begin
				plays     = 1'b1;
				new_track = track_in_q;
			end
			MODE_NEXT: begin
				plays     = count_nz;
				new_track = rem + 16'd1;
			end
			MODE_PREV: begin
				plays     = count_nz;
				new_track = (track_now_q <= 16'd1) ? track_count : track_now_q - 16'd1;
			end
			MODE_REPLAY: begin
				plays     = count_nz;
				new_track = (track_now_q == 16'd0) ? 16'd1 : track_now_q;
			end
			default: begin
				plays     = 1'b0;
				new_track = track_now_q;
			end
		endcase
	end

	assign need_init = !init_done_q && ready && (plays || mode_q == MODE_VOLUME);
	assign has_out   = plays || mode_q == MODE_STOP ||
	                   (mode_q == MODE_VOLUME && (init_done_q || need_init));

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			mode_q      <= command.mode;
			track_in_q  <= command.track;
			volume_in_q <= command.volume_value;
		end
		if (ctl.apply) begin
			if (plays) begin
				main_op_q    <= OP_PLAY_TRACK;
				main_param_q <= new_track;
			end else if (mode_q == MODE_VOLUME) begin
				main_op_q    <= OP_SET_VOLUME;
				main_param_q <= {11'd0, vol_clamped};
			end else begin
				main_op_q    <= OP_STOP;
				main_param_q <= 16'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_done_q  <= 1'b0;
			elapsed_q    <= '0;
			track_now_q  <= '0;
			volume_now_q <= VOLUME_RESET;
		end else if (ctl.apply) begin
			if (mode_q == MODE_TICK && elapsed_q != 16'hFFFF)
				elapsed_q <= elapsed_q + 16'd1;
			if (plays)
				track_now_q <= new_track;
			if (mode_q == MODE_VOLUME)
				volume_now_q <= vol_clamped;
			if (need_init)
				init_done_q <= 1'b1;
		end
	end

	always_comb begin
		unique case (ctl.frame_sel)
			FRM_SELECT: begin
				op    = OP_SELECT_DEVICE;
				param = DEVICE_SD;
			end
			FRM_VOLUME: begin
				op    = OP_SET_VOLUME;
				param = {11'd0, volume_now_q};
			end
			default: begin
				op    = main_op_q;
				param = main_param_q;
			end
		endcase
	end

	assign sum = {8'd0, FRAME_VERSION} + {8'd0, FRAME_LENGTH} + {8'd0, op} +
	             {8'd0, FRAME_NOACK} + {8'd0, param[15:8]} + {8'd0, param[7:0]};
	assign chk = 16'd0 - sum;

	always_comb begin
		unique case (ctl.byte_sel)
			4'd0:    byte_val = FRAME_START;
			4'd1:    byte_val = FRAME_VERSION;
			4'd2:    byte_val = FRAME_LENGTH;
			4'd3:    byte_val = op;
			4'd4:    byte_val = FRAME_NOACK;
			4'd5:    byte_val = param[15:8];
			4'd6:    byte_val = param[7:0];
			4'd7:    byte_val = chk[15:8];
			4'd8:    byte_val = chk[7:0];
			4'd9:    byte_val = FRAME_END;
			default: byte_val = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctl.emit)
			out_valid_q <= 1'b1;
		else if (!frame_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			out_q.frame_byte     <= byte_val;
			out_q.last           <= ctl.last;
			out_q.current_track  <= track_now_q;
			out_q.current_volume <= volume_now_q;
		end
	end

	assign frame_valid = out_valid_q;
	assign frame       = out_q;

	assign status.need_div  = mode_q == MODE_NEXT && count_nz;
	assign status.div_done  = div_done;
	assign status.has_out   = has_out;
	assign status.need_init = need_init;
	assign status.out_free  = !out_valid_q || !frame_stall;

	a_volume_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		volume_now_q <= VOLUME_MAX)
		else $error("stored volume above limit");

	a_elapsed_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.apply |=> elapsed_q >= $past(elapsed_q))
		else $error("elapsed time went backward");

endmodule

@@ rtl/amcs_ctrl.sv @@
// Controller: command intake, remainder wait, state update and frame byte sequencing.
`timescale 1ns / 1ps
module amcs_ctrl
	import amcs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       command_valid,
	output logic       command_stall,
	input  dp_status_t status,
	output ctrl_cmd_t  ctl
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PREP  = 3'd1;
	localparam logic [2:0] S_DIV   = 3'd2;
	localparam logic [2:0] S_APPLY = 3'd3;
	localparam logic [2:0] S_EMIT  = 3'd4;

	logic [2:0] state_q;
	logic [1:0] frame_q;
	logic [3:0] byte_q;
	logic       emit;
	logic       last;

	assign command_stall = state_q != S_IDLE;
	assign emit = state_q == S_EMIT && status.out_free;
	assign last = frame_q == FRM_MAIN && byte_q == BYTE_FINAL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			frame_q <= FRM_MAIN;
			byte_q  <= BYTE_FIRST;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (command_valid)
						state_q <= S_PREP;
				end
				S_PREP: begin
					state_q <= status.need_div ? S_DIV : S_APPLY;
				end
				S_DIV: begin
					if (status.div_done)
						state_q <= S_APPLY;
				end
				S_APPLY: begin
					frame_q <= status.need_init ? FRM_SELECT : FRM_MAIN;
					byte_q  <= BYTE_FIRST;
					state_q <= status.has_out ? S_EMIT : S_IDLE;
				end
				S_EMIT: begin
					if (emit) begin
						if (byte_q == BYTE_FINAL) begin
							byte_q  <= BYTE_FIRST;
							frame_q <= frame_q + 2'd1;
							if (last)
								state_q <= S_IDLE;
						end else begin
							byte_q <= byte_q + 4'd1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign ctl.load      = state_q == S_IDLE && command_valid;
	assign ctl.div_start = state_q == S_PREP && status.need_div;
	assign ctl.apply     = state_q == S_APPLY;
	assign ctl.emit      = emit;
	assign ctl.last      = last;
	assign ctl.frame_sel = frame_q;
	assign ctl.byte_sel  = byte_q;

	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last) |=> state_q == S_IDLE)
		else $error("item continued after final byte");

	a_emit_frame_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> (frame_q != 2'd3 && byte_q <= BYTE_FINAL))
		else $error("frame or byte counter out of range");

endmodule

@@ rtl/audio_module_command_sequencer_top.sv @@
// Top level: configuration registers and controller/datapath wiring.
// Usage:
//   command channel (command_valid / command_stall / command) takes one command per
//   transfer: tick, play, next, previous, replay, stop or set volume.
//   frame channel (frame_valid / frame_stall / frame) returns one serial frame byte
//   per transfer, with last marking the final byte of a command, plus the track
//   and volume in effect after that command.
//   APB port: track_count at 0x0, startup_delay_ms at 0x4; write only while idle.
// Sequencing and throughput:
//   a command is taken in the idle state; commands with no bytes pass prep and apply.
//   a command with bytes emits 10 or 30 bytes, one per cycle while frame_stall is
//   low; the first byte is registered in the emit state, after prep and apply.
//   next with a nonzero track_count adds the div state for the 16-step remainder
//   of the current track by track_count, one bit per cycle in the remainder unit.
//   The next command is taken once the last byte has entered the output register.
// Reset:
//   track_count 0, startup delay 1500 ms, elapsed time 0, track 0, volume 20,
//   init frames pending.
// Stall:
//   a stalled output byte holds; the sequencer waits until it moves on.
`timescale 1ns / 1ps
module audio_module_command_sequencer_top
	import amcs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        command_valid,
	output logic        command_stall,
	input  cmd_item_t   command,
	output logic        frame_valid,
	input  logic        frame_stall,
	output frame_item_t frame,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [15:0] track_count_q;
	logic [15:0] startup_delay_q;
	logic        reg_write;
	ctrl_cmd_t   ctl;
	dp_status_t  status;

	assign pready    = 1'b1;
	assign reg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_count_q   <= TRACK_COUNT_RESET;
			startup_delay_q <= STARTUP_DELAY_RESET;
		end else if (reg_write) begin
			unique case (paddr[2])
				REG_TRACK_COUNT:   track_count_q   <= pwdata[15:0];
				REG_STARTUP_DELAY: startup_delay_q <= pwdata[15:0];
				default:           track_count_q   <= track_count_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_TRACK_COUNT:   prdata = {16'd0, track_count_q};
			REG_STARTUP_DELAY: prdata = {16'd0, startup_delay_q};
			default:           prdata = 32'd0;
		endcase
	end

	amcs_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.command_valid (command_valid),
		.command_stall (command_stall),
		.status        (status),
		.ctl           (ctl)
	);

	amcs_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.command       (command),
		.track_count   (track_count_q),
		.startup_delay (startup_delay_q),
		.ctl           (ctl),
		.status        (status),
		.frame_valid   (frame_valid),
		.frame_stall   (frame_stall),
		.frame         (frame)
	);

endmodule
